// File: rtl/ohrb_pkg.sv
package ohrb_pkg;

  // Fixed port widths
  localparam int WORD_W = 32;
  localparam int IDX_W  = 8;
  localparam int FILL_W = 5;
  localparam int OP_W   = 2;

  // Defaults for the top-level parameters
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUT = 2'd0;
  localparam logic [OP_W-1:0] OP_GET = 2'd1;
  localparam logic [OP_W-1:0] OP_SET = 2'd2;

  // Control for the result register, from the pointer logic
  typedef struct packed {
    logic              valid;
    logic              rd;
    logic              oor;
    logic [FILL_W-1:0] fill;
  } res_ctl_t;

endpackage

// File: rtl/ohrb_ram.sv
module ohrb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/ohrb_ctrl.sv
module ohrb_ctrl #(
  parameter int DEPTH      = ohrb_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = ohrb_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic [ohrb_pkg::OP_W-1:0]         operation_i,
  input  logic signed [ohrb_pkg::IDX_W-1:0] entry_index_i,
  input  logic [ohrb_pkg::WORD_W-1:0]       entry_value_i,
  output logic                              busy_o,
  output logic                              ram_we_o,
  output logic [$clog2(DEPTH)-1:0]          ram_addr_o,
  output logic [DATA_WIDTH-1:0]             ram_wdata_o,
  output ohrb_pkg::res_ctl_t                ctl_o
);
  import ohrb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int TW = ((AW > IDX_W) ? AW : IDX_W) + 3;
  localparam logic signed [TW-1:0] ONE_S   = TW'(1);
  localparam logic signed [TW-1:0] DEPTH_S = TW'(DEPTH);

  logic [AW-1:0] oldest_q, oldest_d;
  logic [AW-1:0] wr_q, wr_d;
  logic [CW-1:0] count_q, count_d;
  // store clearing pass after reset
  logic          clr_q, clr_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;

  // Set index reduced modulo DEPTH, one entry per index code
  logic [AW-1:0] set_age_tbl [256];

  for (genvar k = 0; k < 256; k++) begin : g_age
    localparam int SIdx = (k >= 128) ? k - 256 : k;
    localparam int SAge = ((SIdx % DEPTH) + DEPTH) % DEPTH;
    assign set_age_tbl[k] = AW'(SAge);
  end

  logic [AW-1:0]          set_age;
  logic signed [TW-1:0]   cnt_s, idx_s, age_s, rel_s, slot_s;
  logic                   get_oor;
  logic                   set_prepend;
  logic [AW-1:0]          wr_inc, oldest_inc, oldest_dec;

  assign busy_o = clr_q;

  always_comb begin
    set_age = set_age_tbl[$unsigned(entry_index_i)];
    cnt_s   = TW'(count_q);
    idx_s   = TW'(entry_index_i);
    age_s   = TW'(set_age);
    get_oor     = (idx_s >= cnt_s) || (idx_s < -cnt_s);
    set_prepend = (age_s >= cnt_s);

    // age counted back from the newest slot, wrapped once either way
    rel_s = TW'(wr_q) - ONE_S - ((operation_i == OP_SET) ? age_s : idx_s);
    if (rel_s < 0) begin
      slot_s = rel_s + DEPTH_S;
    end else if (rel_s >= DEPTH_S) begin
      slot_s = rel_s - DEPTH_S;
    end else begin
      slot_s = rel_s;
    end

    wr_inc     = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    oldest_inc = (oldest_q == AW'(DEPTH - 1)) ? '0 : oldest_q + 1'b1;
    oldest_dec = (oldest_q == '0) ? AW'(DEPTH - 1) : oldest_q - 1'b1;
  end

  always_comb begin
    oldest_d    = oldest_q;
    wr_d        = wr_q;
    count_d     = count_q;
    clr_d       = clr_q;
    clr_addr_d  = clr_addr_q;
    ram_we_o    = 1'b0;
    ram_addr_o  = slot_s[AW-1:0];
    ram_wdata_o = DATA_WIDTH'(entry_value_i);
    ctl_o.valid = accept_i;
    ctl_o.rd    = 1'b0;
    ctl_o.oor   = 1'b0;
    if (clr_q) begin
      // one zero write per cycle, no transfer possible while busy
      ram_we_o    = 1'b1;
      ram_addr_o  = clr_addr_q;
      ram_wdata_o = '0;
      clr_addr_d  = clr_addr_q + 1'b1;
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_d = 1'b0;
      end
    end else if (accept_i) begin
      case (operation_i)
        OP_PUT: begin
          ram_we_o   = 1'b1;
          ram_addr_o = wr_q;
          wr_d       = wr_inc;
          if (count_q == CW'(DEPTH)) begin
            oldest_d = oldest_inc;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
        OP_GET: begin
          ctl_o.oor = get_oor;
          ctl_o.rd  = ~get_oor;
        end
        OP_SET: begin
          ram_we_o = 1'b1;
          if (set_prepend) begin
            oldest_d   = oldest_dec;
            count_d    = count_q + 1'b1;
            ram_addr_o = oldest_dec;
          end
        end
        default: begin
        end
      endcase
    end
    ctl_o.fill = FILL_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q   <= '0;
      wr_q       <= '0;
      count_q    <= '0;
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      oldest_q   <= oldest_d;
      wr_q       <= wr_d;
      count_q    <= count_d;
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("fill exceeds depth");

  a_ptr_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((AW + 2)'(oldest_q) + (AW + 2)'(count_q) == (AW + 2)'(wr_q)) ||
    ((AW + 2)'(oldest_q) + (AW + 2)'(count_q) == (AW + 2)'(wr_q) + (AW + 2)'(DEPTH)))
    else $error("oldest plus fill does not meet write position");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1))
    else $error("fill moved by more than one");

endmodule

// File: rtl/overwrite_history_ring_buffer.sv
// History ring of DEPTH words addressed by age from the newest entry.
// Command channel: drive operation_i, entry_index_i and entry_value_i with
// start_i high; the command transfers at a rising edge where busy_o is low.
// Operations: put appends (overwriting the oldest when full), get reads by
// signed age, set rewrites by age or prepends a new oldest entry.
// Result channel: result_valid_o pulses for one cycle, the cycle right after
// the command transfer, with read_data_o, out_of_range_o and fill_count_o.
// Throughput is one command per cycle while busy_o is low; each command
// makes one access to the single-port store, whose read is registered.
// Results come out in command order.
// The receiver cannot stall: a result strobe is taken in its own cycle.
// Reset clears the pointers and the fill count; after reset busy_o stays
// high while the store is written to zero, one entry per cycle, and busy_o
// is never raised again.
module overwrite_history_ring_buffer #(
  parameter int DEPTH      = ohrb_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = ohrb_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [ohrb_pkg::OP_W-1:0]         operation_i,
  input  logic signed [ohrb_pkg::IDX_W-1:0] entry_index_i,
  input  logic [ohrb_pkg::WORD_W-1:0]       entry_value_i,
  output logic                              result_valid_o,
  output logic [ohrb_pkg::WORD_W-1:0]       read_data_o,
  output logic                              out_of_range_o,
  output logic [ohrb_pkg::FILL_W-1:0]       fill_count_o
);
  import ohrb_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic                  accept;
  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
  res_ctl_t              ctl_d, ctl_q;

  assign accept = start_i & ~busy_o;

  ohrb_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .operation_i   (operation_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .busy_o        (busy_o),
    .ram_we_o      (ram_we),
    .ram_addr_o    (ram_addr),
    .ram_wdata_o   (ram_wdata),
    .ctl_o         (ctl_d)
  );

  ohrb_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  assign result_valid_o = ctl_q.valid;
  assign read_data_o    = ctl_q.rd ? WORD_W'(ram_rdata) : '0;
  assign out_of_range_o = ctl_q.oor;
  assign fill_count_o   = ctl_q.fill;

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> result_valid_o)
    else $error("transfer without a result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !result_valid_o)
    else $error("result without a transfer");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_of_range_o |-> (result_valid_o && read_data_o == '0))
    else $error("out-of-range get returned data");

endmodule
